// ===== rtl/cpu8x_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8x_pkg
// Shared types and operation codes of the 8-bit register and ALU execute unit.
// ----------------------------------------------------------------------------
package cpu8x_pkg;

  // Operation codes. Codes above CMD_BEQ behave as no operation.
  localparam logic [5:0] CMD_NOP = 6'd0;
  localparam logic [5:0] CMD_LDA = 6'd1;
  localparam logic [5:0] CMD_LDX = 6'd2;
  localparam logic [5:0] CMD_LDY = 6'd3;
  localparam logic [5:0] CMD_TAX = 6'd4;
  localparam logic [5:0] CMD_TAY = 6'd5;
  localparam logic [5:0] CMD_TXA = 6'd6;
  localparam logic [5:0] CMD_TYA = 6'd7;
  localparam logic [5:0] CMD_TSX = 6'd8;
  localparam logic [5:0] CMD_TXS = 6'd9;
  localparam logic [5:0] CMD_INX = 6'd10;
  localparam logic [5:0] CMD_INY = 6'd11;
  localparam logic [5:0] CMD_DEX = 6'd12;
  localparam logic [5:0] CMD_DEY = 6'd13;
  localparam logic [5:0] CMD_ADC = 6'd14;
  localparam logic [5:0] CMD_SBC = 6'd15;
  localparam logic [5:0] CMD_AND = 6'd16;
  localparam logic [5:0] CMD_ORA = 6'd17;
  localparam logic [5:0] CMD_EOR = 6'd18;
  localparam logic [5:0] CMD_CMP = 6'd19;
  localparam logic [5:0] CMD_CPX = 6'd20;
  localparam logic [5:0] CMD_CPY = 6'd21;
  localparam logic [5:0] CMD_BIT = 6'd22;
  localparam logic [5:0] CMD_ASL = 6'd23;
  localparam logic [5:0] CMD_LSR = 6'd24;
  localparam logic [5:0] CMD_ROL = 6'd25;
  localparam logic [5:0] CMD_ROR = 6'd26;
  localparam logic [5:0] CMD_INC = 6'd27;
  localparam logic [5:0] CMD_DEC = 6'd28;
  localparam logic [5:0] CMD_CLC = 6'd29;
  localparam logic [5:0] CMD_SEC = 6'd30;
  localparam logic [5:0] CMD_CLI = 6'd31;
  localparam logic [5:0] CMD_SEI = 6'd32;
  localparam logic [5:0] CMD_CLD = 6'd33;
  localparam logic [5:0] CMD_SED = 6'd34;
  localparam logic [5:0] CMD_CLV = 6'd35;
  localparam logic [5:0] CMD_BPL = 6'd36;
  localparam logic [5:0] CMD_BEQ = 6'd43;

  // Branch flag selectors, taken from bits 2:1 of the code offset from CMD_BPL.
  localparam logic [1:0] BR_SEL_N = 2'd0;
  localparam logic [1:0] BR_SEL_V = 2'd1;
  localparam logic [1:0] BR_SEL_C = 2'd2;
  localparam logic [1:0] BR_SEL_Z = 2'd3;

  localparam logic [7:0] SP_RESET = 8'hFD;

  typedef struct packed {
    logic       n;
    logic       v;
    logic       d;
    logic       i;
    logic       z;
    logic       c;
  } flags_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    flags_t     flags;
  } arch_t;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [7:0]  operand;
    logic        use_accumulator;
    logic [15:0] next_pc;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [7:0]  mem_data_out;
    logic        branch_taken;
    logic [15:0] target_pc;
    logic        page_crossed;
  } out_word_t;

  typedef struct packed {
    logic        taken;
    logic [15:0] target;
    logic        crossed;
  } br_t;

endpackage

// ===== rtl/cpu8x_branch.sv =====
// ----------------------------------------------------------------------------
// cpu8x_branch
// Conditional branch test, signed offset add and page-cross detection.
// ----------------------------------------------------------------------------
module cpu8x_branch (
  input  logic [5:0]        cmd,
  input  logic [7:0]        operand,
  input  logic [15:0]       next_pc,
  input  cpu8x_pkg::flags_t flags,
  output cpu8x_pkg::br_t    br
);

  logic [5:0]  br_off;
  logic        is_branch;
  logic        flag_val;
  logic [15:0] sum;

  assign br_off    = cmd - cpu8x_pkg::CMD_BPL;
  assign is_branch = (cmd >= cpu8x_pkg::CMD_BPL) && (cmd <= cpu8x_pkg::CMD_BEQ);
  assign sum       = next_pc + {{8{operand[7]}}, operand};

  always_comb begin
    case (br_off[2:1])
      cpu8x_pkg::BR_SEL_N: flag_val = flags.n;
      cpu8x_pkg::BR_SEL_V: flag_val = flags.v;
      cpu8x_pkg::BR_SEL_C: flag_val = flags.c;
      cpu8x_pkg::BR_SEL_Z: flag_val = flags.z;
      default:             flag_val = 1'b0;
    endcase
  end

  // Odd codes branch on a set flag, even codes on a clear one.
  always_comb begin
    br.taken   = is_branch && (br_off[0] ? flag_val : !flag_val);
    br.target  = br.taken ? sum : next_pc;
    br.crossed = br.taken && (sum[15:8] != next_pc[15:8]);
  end

endmodule

// ===== rtl/cpu8x_alu.sv =====
// ----------------------------------------------------------------------------
// cpu8x_alu
// Register, ALU and flag update for one operation.
// ----------------------------------------------------------------------------
module cpu8x_alu (
  input  cpu8x_pkg::in_word_t item,
  input  cpu8x_pkg::arch_t    cur,
  output cpu8x_pkg::arch_t    nxt,
  output logic [7:0]          mem_data
);

  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] sh_in;
  logic [7:0] sh_res;
  logic       sh_carry;
  logic [7:0] nz_val;
  logic       nz_en;

  assign addend = (item.cmd == cpu8x_pkg::CMD_SBC) ? ~item.operand : item.operand;
  assign sum    = {1'b0, cur.acc} + {1'b0, addend} + {8'd0, cur.flags.c};
  assign sh_in  = item.use_accumulator ? cur.acc : item.operand;

  always_comb begin
    case (item.cmd)
      cpu8x_pkg::CMD_CPX: cmp_reg = cur.x;
      cpu8x_pkg::CMD_CPY: cmp_reg = cur.y;
      default:            cmp_reg = cur.acc;
    endcase
  end

  // A borrow in bit 8 means the register was below the operand.
  assign diff = {1'b0, cmp_reg} - {1'b0, item.operand};

  always_comb begin
    case (item.cmd)
      cpu8x_pkg::CMD_ASL: begin
        sh_res   = {sh_in[6:0], 1'b0};
        sh_carry = sh_in[7];
      end
      cpu8x_pkg::CMD_LSR: begin
        sh_res   = {1'b0, sh_in[7:1]};
        sh_carry = sh_in[0];
      end
      cpu8x_pkg::CMD_ROL: begin
        sh_res   = {sh_in[6:0], cur.flags.c};
        sh_carry = sh_in[7];
      end
      default: begin
        sh_res   = {cur.flags.c, sh_in[7:1]};
        sh_carry = sh_in[0];
      end
    endcase
  end

  always_comb begin
    nxt      = cur;
    mem_data = 8'd0;
    nz_val   = 8'd0;
    nz_en    = 1'b0;
    case (item.cmd)
      cpu8x_pkg::CMD_LDA: begin nxt.acc = item.operand; nz_val = item.operand; nz_en = 1'b1; end
      cpu8x_pkg::CMD_LDX: begin nxt.x = item.operand; nz_val = item.operand; nz_en = 1'b1; end
      cpu8x_pkg::CMD_LDY: begin nxt.y = item.operand; nz_val = item.operand; nz_en = 1'b1; end
      cpu8x_pkg::CMD_TAX: begin nxt.x = cur.acc; nz_val = cur.acc; nz_en = 1'b1; end
      cpu8x_pkg::CMD_TAY: begin nxt.y = cur.acc; nz_val = cur.acc; nz_en = 1'b1; end
      cpu8x_pkg::CMD_TXA: begin nxt.acc = cur.x; nz_val = cur.x; nz_en = 1'b1; end
      cpu8x_pkg::CMD_TYA: begin nxt.acc = cur.y; nz_val = cur.y; nz_en = 1'b1; end
      cpu8x_pkg::CMD_TSX: begin nxt.x = cur.sp; nz_val = cur.sp; nz_en = 1'b1; end
      cpu8x_pkg::CMD_TXS: nxt.sp = cur.x;
      cpu8x_pkg::CMD_INX: begin
        nxt.x = cur.x + 8'd1; nz_val = nxt.x; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_INY: begin
        nxt.y = cur.y + 8'd1; nz_val = nxt.y; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_DEX: begin
        nxt.x = cur.x - 8'd1; nz_val = nxt.x; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_DEY: begin
        nxt.y = cur.y - 8'd1; nz_val = nxt.y; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_ADC, cpu8x_pkg::CMD_SBC: begin
        nxt.acc     = sum[7:0];
        nxt.flags.c = sum[8];
        nxt.flags.v = (cur.acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
        nz_val      = sum[7:0];
        nz_en       = 1'b1;
      end
      cpu8x_pkg::CMD_AND: begin
        nxt.acc = cur.acc & item.operand; nz_val = nxt.acc; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_ORA: begin
        nxt.acc = cur.acc | item.operand; nz_val = nxt.acc; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_EOR: begin
        nxt.acc = cur.acc ^ item.operand; nz_val = nxt.acc; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_CMP, cpu8x_pkg::CMD_CPX, cpu8x_pkg::CMD_CPY: begin
        nxt.flags.c = !diff[8];
        nz_val      = diff[7:0];
        nz_en       = 1'b1;
      end
      cpu8x_pkg::CMD_BIT: begin
        nxt.flags.z = ((cur.acc & item.operand) == 8'd0);
        nxt.flags.n = item.operand[7];
        nxt.flags.v = item.operand[6];
      end
      cpu8x_pkg::CMD_ASL, cpu8x_pkg::CMD_LSR, cpu8x_pkg::CMD_ROL, cpu8x_pkg::CMD_ROR: begin
        nxt.flags.c = sh_carry;
        nz_val      = sh_res;
        nz_en       = 1'b1;
        if (item.use_accumulator) begin
          nxt.acc = sh_res;
        end else begin
          mem_data = sh_res;
        end
      end
      cpu8x_pkg::CMD_INC: begin
        mem_data = item.operand + 8'd1; nz_val = mem_data; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_DEC: begin
        mem_data = item.operand - 8'd1; nz_val = mem_data; nz_en = 1'b1;
      end
      cpu8x_pkg::CMD_CLC: nxt.flags.c = 1'b0;
      cpu8x_pkg::CMD_SEC: nxt.flags.c = 1'b1;
      cpu8x_pkg::CMD_CLI: nxt.flags.i = 1'b0;
      cpu8x_pkg::CMD_SEI: nxt.flags.i = 1'b1;
      cpu8x_pkg::CMD_CLD: nxt.flags.d = 1'b0;
      cpu8x_pkg::CMD_SED: nxt.flags.d = 1'b1;
      cpu8x_pkg::CMD_CLV: nxt.flags.v = 1'b0;
      default: ;
    endcase
    if (nz_en) begin
      nxt.flags.n = nz_val[7];
      nxt.flags.z = (nz_val == 8'd0);
    end
  end

endmodule

// ===== rtl/cpu8_register_alu_execute.sv =====
// ----------------------------------------------------------------------------
// cpu8_register_alu_execute
// Execute unit of an 8-bit CPU: A, X, Y, SP and N V D I Z C flags with
// loads, transfers, binary arithmetic, logic, shifts and conditional branches.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                             Word
//   --------  --------------------------------  ----------------------------
//   input     in_valid, in_stall, in_data       one decoded operation
//   result    out_valid, out_stall, out_data    registers, flags, branch
//
// An accepted word waits in the input register; at the next edge with a free
// result register it passes through the ALU and branch logic into the result
// register. The result register frees at the edge its word is taken, so
// back-to-back words flow with no bubble; while out_stall holds it full,
// in_stall rises as soon as the input register also holds a word.
// Synchronous reset empties both stages, clears A, X, Y, sets SP to 0xFD and I.
//
module cpu8_register_alu_execute (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cpu8x_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cpu8x_pkg::out_word_t  out_data
);

  cpu8x_pkg::in_word_t  in_r;
  logic                 in_valid_r;
  logic                 in_valid_nxt;
  cpu8x_pkg::out_word_t out_r;
  cpu8x_pkg::out_word_t out_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  cpu8x_pkg::arch_t     arch_r;
  cpu8x_pkg::arch_t     arch_nxt;
  logic [7:0]           mem_data;
  cpu8x_pkg::br_t       br;
  logic                 out_free;
  logic                 exec_fire;
  logic                 in_take;

  // The result register can take a new word when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_fire = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !exec_fire;
  assign in_take   = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !exec_fire);
  assign out_valid_nxt = exec_fire || (out_valid_r && out_stall);

  cpu8x_alu u_alu (
    .item     (in_r),
    .cur      (arch_r),
    .nxt      (arch_nxt),
    .mem_data (mem_data)
  );

  // Branches test the flags as they stand before this operation.
  cpu8x_branch u_branch (
    .cmd     (in_r.cmd),
    .operand (in_r.operand),
    .next_pc (in_r.next_pc),
    .flags   (arch_r.flags),
    .br      (br)
  );

  // Status byte layout is N V 1 B D I Z C; bit 5 reads one and B reads zero.
  always_comb begin
    out_nxt.acc_out      = arch_nxt.acc;
    out_nxt.x_out        = arch_nxt.x;
    out_nxt.y_out        = arch_nxt.y;
    out_nxt.sp_out       = arch_nxt.sp;
    out_nxt.status_out   = {arch_nxt.flags.n, arch_nxt.flags.v, 1'b1, 1'b0,
                            arch_nxt.flags.d, arch_nxt.flags.i,
                            arch_nxt.flags.z, arch_nxt.flags.c};
    out_nxt.mem_data_out = mem_data;
    out_nxt.branch_taken = br.taken;
    out_nxt.target_pc    = br.target;
    out_nxt.page_crossed = br.crossed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      arch_r.acc  <= 8'd0;
      arch_r.x    <= 8'd0;
      arch_r.y    <= 8'd0;
      arch_r.sp   <= cpu8x_pkg::SP_RESET;
      arch_r.flags <= '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0};
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        arch_r <= arch_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (exec_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // Architectural registers move only when an operation executes.
  a_arch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_fire |=> $stable(arch_r))
    else $error("architectural state changed without an executed word");

  // A word waiting in the input register is neither lost nor altered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !exec_fire |=> in_valid_r && $stable(in_r))
    else $error("input register lost its word");

  // A word with a free result register moves on in the next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_free |=> out_valid_r)
    else $error("word did not reach the result register");

  // Fixed status bits and branch consistency in presented results.
  a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.status_out[5] && !out_r.status_out[4])
    else $error("status fixed bits wrong");

  a_cross_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.branch_taken |-> !out_r.page_crossed)
    else $error("page cross flagged on an untaken branch");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit register and ALU execute unit. A short
// list of directed operations is followed by random ones; every result word
// is compared field by field with a hand-written or predicted result.
// ----------------------------------------------------------------------------
module tb_top;

  // The package names only the first and last branch codes; the others lie
  // between in order; every code above the last behaves as no operation.
  localparam logic [5:0] CMD_BMI = cpu8x_pkg::CMD_BPL + 6'd1;
  localparam logic [5:0] CMD_BVC = cpu8x_pkg::CMD_BPL + 6'd2;
  localparam logic [5:0] CMD_BVS = cpu8x_pkg::CMD_BPL + 6'd3;
  localparam logic [5:0] CMD_BCC = cpu8x_pkg::CMD_BPL + 6'd4;
  localparam logic [5:0] CMD_BCS = cpu8x_pkg::CMD_BPL + 6'd5;
  localparam logic [5:0] CMD_BNE = cpu8x_pkg::CMD_BPL + 6'd6;
  localparam logic [5:0] CMD_UNUSED_LO = cpu8x_pkg::CMD_BEQ + 6'd1;
  localparam logic [5:0] CMD_UNUSED_HI = 6'h3F;

  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cpu8x_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cpu8x_pkg::out_word_t out_data;

  cpu8_register_alu_execute u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted architectural state, advanced once per accepted word.
  logic [7:0]        a_reg = 8'h00;
  logic [7:0]        x_reg = 8'h00;
  logic [7:0]        y_reg = 8'h00;
  logic [7:0]        sp_reg = cpu8x_pkg::SP_RESET;
  cpu8x_pkg::flags_t fl = '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0};

  // Result words still owed by the block, oldest first.
  cpu8x_pkg::out_word_t exp_q[$];
  int                   mismatch_cnt = 0;
  int                   cycle_cnt = 0;
  int                   burst_left = 0;

  // A directed row either carries a hand-written result or leaves the
  // result to the predictor.
  typedef struct {
    cpu8x_pkg::in_word_t  w;
    bit                   fixed;
    cpu8x_pkg::out_word_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void set_nz(input logic [7:0] v);
    fl.n = v[7];
    fl.z = (v == 8'h00);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    fl.c = (r >= m);
    set_nz(r - m);
  endfunction

  // Shifts and rotates: the carry takes the bit pushed out, rotates feed the
  // old carry back in at the other end.
  function automatic logic [7:0] shift_rot(input logic [5:0] op, input logic [7:0] v);
    logic [7:0] res;
    logic       cin;
    cin = fl.c;
    case (op)
      cpu8x_pkg::CMD_ASL: begin
        fl.c = v[7];
        res = {v[6:0], 1'b0};
      end
      cpu8x_pkg::CMD_LSR: begin
        fl.c = v[0];
        res = {1'b0, v[7:1]};
      end
      cpu8x_pkg::CMD_ROL: begin
        fl.c = v[7];
        res = {v[6:0], cin};
      end
      default: begin
        fl.c = v[0];
        res = {cin, v[7:1]};
      end
    endcase
    set_nz(res);
    return res;
  endfunction

  // Executes one operation on the predicted state and returns the word the
  // block should present for it. Add and subtract are always binary.
  function automatic cpu8x_pkg::out_word_t exec_op(input cpu8x_pkg::in_word_t w);
    cpu8x_pkg::out_word_t r;
    logic [7:0]           m;
    logic [7:0]           addend;
    logic [8:0]           sum;
    logic [7:0]           mem;
    logic [5:0]           br_ofs;
    logic                 cond;
    logic [15:0]          tgt;
    m = w.operand;
    mem = 8'h00;
    r = '0;
    r.target_pc = w.next_pc;
    case (w.cmd)
      cpu8x_pkg::CMD_LDA: begin a_reg = m; set_nz(a_reg); end
      cpu8x_pkg::CMD_LDX: begin x_reg = m; set_nz(x_reg); end
      cpu8x_pkg::CMD_LDY: begin y_reg = m; set_nz(y_reg); end
      cpu8x_pkg::CMD_TAX: begin x_reg = a_reg; set_nz(x_reg); end
      cpu8x_pkg::CMD_TAY: begin y_reg = a_reg; set_nz(y_reg); end
      cpu8x_pkg::CMD_TXA: begin a_reg = x_reg; set_nz(a_reg); end
      cpu8x_pkg::CMD_TYA: begin a_reg = y_reg; set_nz(a_reg); end
      cpu8x_pkg::CMD_TSX: begin x_reg = sp_reg; set_nz(x_reg); end
      cpu8x_pkg::CMD_TXS: sp_reg = x_reg;
      cpu8x_pkg::CMD_INX: begin x_reg = x_reg + 8'd1; set_nz(x_reg); end
      cpu8x_pkg::CMD_INY: begin y_reg = y_reg + 8'd1; set_nz(y_reg); end
      cpu8x_pkg::CMD_DEX: begin x_reg = x_reg - 8'd1; set_nz(x_reg); end
      cpu8x_pkg::CMD_DEY: begin y_reg = y_reg - 8'd1; set_nz(y_reg); end
      cpu8x_pkg::CMD_ADC, cpu8x_pkg::CMD_SBC: begin
        // Subtraction adds the complement of the operand plus the carry.
        addend = (w.cmd == cpu8x_pkg::CMD_SBC) ? ~m : m;
        sum = {1'b0, a_reg} + {1'b0, addend} + {8'h00, fl.c};
        fl.c = sum[8];
        fl.v = (a_reg[7] ^ sum[7]) & (addend[7] ^ sum[7]);
        a_reg = sum[7:0];
        set_nz(a_reg);
      end
      cpu8x_pkg::CMD_AND: begin a_reg = a_reg & m; set_nz(a_reg); end
      cpu8x_pkg::CMD_ORA: begin a_reg = a_reg | m; set_nz(a_reg); end
      cpu8x_pkg::CMD_EOR: begin a_reg = a_reg ^ m; set_nz(a_reg); end
      cpu8x_pkg::CMD_CMP: compare_reg(a_reg, m);
      cpu8x_pkg::CMD_CPX: compare_reg(x_reg, m);
      cpu8x_pkg::CMD_CPY: compare_reg(y_reg, m);
      cpu8x_pkg::CMD_BIT: begin
        fl.z = ((a_reg & m) == 8'h00);
        fl.n = m[7];
        fl.v = m[6];
      end
      cpu8x_pkg::CMD_ASL, cpu8x_pkg::CMD_LSR, cpu8x_pkg::CMD_ROL, cpu8x_pkg::CMD_ROR: begin
        if (w.use_accumulator) begin
          a_reg = shift_rot(w.cmd, a_reg);
        end else begin
          mem = shift_rot(w.cmd, m);
        end
      end
      // Memory increment and decrement ignore the accumulator select.
      cpu8x_pkg::CMD_INC: begin mem = m + 8'd1; set_nz(mem); end
      cpu8x_pkg::CMD_DEC: begin mem = m - 8'd1; set_nz(mem); end
      cpu8x_pkg::CMD_CLC: fl.c = 1'b0;
      cpu8x_pkg::CMD_SEC: fl.c = 1'b1;
      cpu8x_pkg::CMD_CLI: fl.i = 1'b0;
      cpu8x_pkg::CMD_SEI: fl.i = 1'b1;
      cpu8x_pkg::CMD_CLD: fl.d = 1'b0;
      cpu8x_pkg::CMD_SED: fl.d = 1'b1;
      cpu8x_pkg::CMD_CLV: fl.v = 1'b0;
      default: begin
        // Branches pick a flag by code pair; odd codes branch on a set flag.
        if (w.cmd >= cpu8x_pkg::CMD_BPL && w.cmd <= cpu8x_pkg::CMD_BEQ) begin
          br_ofs = w.cmd - cpu8x_pkg::CMD_BPL;
          case (br_ofs[2:1])
            cpu8x_pkg::BR_SEL_N: cond = fl.n;
            cpu8x_pkg::BR_SEL_V: cond = fl.v;
            cpu8x_pkg::BR_SEL_C: cond = fl.c;
            cpu8x_pkg::BR_SEL_Z: cond = fl.z;
            default:             cond = 1'b0;
          endcase
          if (br_ofs[0] ? cond : !cond) begin
            tgt = w.next_pc + {{8{m[7]}}, m};
            r.branch_taken = 1'b1;
            r.target_pc = tgt;
            r.page_crossed = (tgt[15:8] != w.next_pc[15:8]);
          end
        end
      end
    endcase
    r.acc_out = a_reg;
    r.x_out = x_reg;
    r.y_out = y_reg;
    r.sp_out = sp_reg;
    r.status_out = {fl.n, fl.v, 1'b1, 1'b0, fl.d, fl.i, fl.z, fl.c};
    r.mem_data_out = mem;
    return r;
  endfunction

  function automatic cpu8x_pkg::in_word_t mk(input logic [5:0] c, input logic [7:0] o,
                                             input logic ua, input logic [15:0] pc);
    cpu8x_pkg::in_word_t w;
    w.cmd = c;
    w.operand = o;
    w.use_accumulator = ua;
    w.next_pc = pc;
    return w;
  endfunction

  function automatic void add_row(input cpu8x_pkg::in_word_t w);
    dir_rows.push_back('{w, 1'b0, '0});
  endfunction

  function automatic void add_fixed(input cpu8x_pkg::in_word_t w,
                                    input cpu8x_pkg::out_word_t e);
    dir_rows.push_back('{w, 1'b1, e});
  endfunction

  // Random words lean on the operand extremes and on program counters close
  // to a page edge, so that carries, overflows and page crossings show up.
  function automatic cpu8x_pkg::in_word_t rand_word();
    cpu8x_pkg::in_word_t w;
    int unsigned         pick;
    logic [7:0]          edges[7];
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      w.cmd = cpu8x_pkg::CMD_NOP;
    end else if (pick < 10) begin
      w.cmd = 6'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end else begin
      w.cmd = 6'($urandom_range(cpu8x_pkg::CMD_LDA, cpu8x_pkg::CMD_BEQ));
    end
    if ($urandom_range(0, 3) == 0) begin
      w.operand = edges[3'($urandom_range(0, 6))];
    end else begin
      w.operand = 8'($urandom);
    end
    w.use_accumulator = 1'($urandom);
    w.next_pc = 16'($urandom);
    if ($urandom_range(0, 9) < 3) begin
      w.next_pc[7:0] = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hFF))
                                            : 8'($urandom_range(8'h00, 8'h0F));
    end
    return w;
  endfunction

  // Presents one word and holds it until the block takes it. The sender
  // works in bursts; between bursts it drops valid.
  task automatic send_word(input cpu8x_pkg::in_word_t w, input bit fixed,
                           input cpu8x_pkg::out_word_t want);
    cpu8x_pkg::out_word_t pred;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(posedge clk);
    end while (in_stall);
    pred = exec_op(w);
    exp_q.push_back(fixed ? want : pred);
    burst_left--;
  endtask

  // Holds the sender off until every owed result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (exp_q.size() != 0);
  endtask

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
    end
  endfunction

  // Receiver: stalls on a pattern of its own that is picked anew at random,
  // from never stalling through random stalls to long solid runs.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= stall_left[4];
      endcase
    end
  end

  // Every word taken from the block must match the oldest owed word.
  always @(posedge clk) begin : result_check
    cpu8x_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result word expected none got %0h", $time, out_data);
      end else begin
        want = exp_q.pop_front();
        check_field("acc_out", 16'(want.acc_out), 16'(out_data.acc_out));
        check_field("x_out", 16'(want.x_out), 16'(out_data.x_out));
        check_field("y_out", 16'(want.y_out), 16'(out_data.y_out));
        check_field("sp_out", 16'(want.sp_out), 16'(out_data.sp_out));
        check_field("status_out", 16'(want.status_out), 16'(out_data.status_out));
        check_field("mem_data_out", 16'(want.mem_data_out), 16'(out_data.mem_data_out));
        check_field("branch_taken", 16'(want.branch_taken), 16'(out_data.branch_taken));
        check_field("target_pc", want.target_pc, out_data.target_pc);
        check_field("page_crossed", 16'(want.page_crossed), 16'(out_data.page_crossed));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // The first rows start from the reset state: zero registers, SP at 0xFD,
    // only interrupt-disable set; their results are written by hand.
    add_fixed(mk(cpu8x_pkg::CMD_NOP, 8'hFF, 1'b1, 16'hFFFF),
              '{8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 8'h00, 1'b0, 16'hFFFF, 1'b0});
    add_fixed(mk(cpu8x_pkg::CMD_LDA, 8'hFF, 1'b0, 16'h0000),
              '{8'hFF, 8'h00, 8'h00, 8'hFD, 8'hA4, 8'h00, 1'b0, 16'h0000, 1'b0});
    add_fixed(mk(cpu8x_pkg::CMD_LDA, 8'h00, 1'b1, 16'h8000),
              '{8'h00, 8'h00, 8'h00, 8'hFD, 8'h26, 8'h00, 1'b0, 16'h8000, 1'b0});
    // Taken branch with the most negative offset wraps below address zero.
    add_fixed(mk(cpu8x_pkg::CMD_BEQ, 8'h80, 1'b0, 16'h0000),
              '{8'h00, 8'h00, 8'h00, 8'hFD, 8'h26, 8'h00, 1'b1, 16'hFF80, 1'b1});
    // Untaken branch leaves the program counter alone.
    add_fixed(mk(CMD_BNE, 8'h7F, 1'b1, 16'hFFFF),
              '{8'h00, 8'h00, 8'h00, 8'hFD, 8'h26, 8'h00, 1'b0, 16'hFFFF, 1'b0});
    add_row(mk(cpu8x_pkg::CMD_LDX, 8'h80, 1'b0, 16'h1000));
    add_row(mk(cpu8x_pkg::CMD_LDY, 8'h7F, 1'b1, 16'h1001));
    add_row(mk(cpu8x_pkg::CMD_TAX, 8'h00, 1'b0, 16'h1002));
    add_row(mk(cpu8x_pkg::CMD_TAY, 8'h00, 1'b0, 16'h1003));
    add_row(mk(cpu8x_pkg::CMD_LDA, 8'h81, 1'b0, 16'h1004));
    add_row(mk(cpu8x_pkg::CMD_TXA, 8'h00, 1'b0, 16'h1005));
    add_row(mk(cpu8x_pkg::CMD_TYA, 8'h00, 1'b0, 16'h1006));
    add_row(mk(cpu8x_pkg::CMD_TSX, 8'h00, 1'b0, 16'h1007));
    add_row(mk(cpu8x_pkg::CMD_LDX, 8'h00, 1'b0, 16'h1008));
    // Moving X into the stack pointer touches no flag.
    add_row(mk(cpu8x_pkg::CMD_TXS, 8'hFF, 1'b1, 16'h1009));
    add_row(mk(cpu8x_pkg::CMD_INX, 8'h00, 1'b0, 16'h100A));
    add_row(mk(cpu8x_pkg::CMD_INY, 8'h00, 1'b0, 16'h100B));
    add_row(mk(cpu8x_pkg::CMD_DEX, 8'h00, 1'b0, 16'h100C));
    add_row(mk(cpu8x_pkg::CMD_DEY, 8'h00, 1'b0, 16'h100D));
    add_row(mk(cpu8x_pkg::CMD_LDA, 8'h7F, 1'b0, 16'h100E));
    add_row(mk(cpu8x_pkg::CMD_CLC, 8'h00, 1'b0, 16'h100F));
    // Signed overflow on 0x7F + 1, then carry and borrow paths.
    add_row(mk(cpu8x_pkg::CMD_ADC, 8'h01, 1'b0, 16'h1010));
    add_row(mk(cpu8x_pkg::CMD_SEC, 8'h00, 1'b0, 16'h1011));
    add_row(mk(cpu8x_pkg::CMD_SBC, 8'h01, 1'b0, 16'h1012));
    add_row(mk(cpu8x_pkg::CMD_ADC, 8'hFF, 1'b0, 16'h1013));
    add_row(mk(cpu8x_pkg::CMD_SBC, 8'hFF, 1'b1, 16'h1014));
    add_row(mk(cpu8x_pkg::CMD_AND, 8'h0F, 1'b0, 16'h1015));
    add_row(mk(cpu8x_pkg::CMD_ORA, 8'hF0, 1'b0, 16'h1016));
    add_row(mk(cpu8x_pkg::CMD_EOR, 8'hFF, 1'b0, 16'h1017));
    add_row(mk(cpu8x_pkg::CMD_CMP, 8'h00, 1'b0, 16'h1018));
    add_row(mk(cpu8x_pkg::CMD_CPX, 8'hFF, 1'b0, 16'h1019));
    add_row(mk(cpu8x_pkg::CMD_CPY, 8'h7F, 1'b0, 16'h101A));
    add_row(mk(cpu8x_pkg::CMD_BIT, 8'hC0, 1'b0, 16'h101B));
    add_row(mk(cpu8x_pkg::CMD_BIT, 8'h00, 1'b1, 16'h101C));
    add_row(mk(cpu8x_pkg::CMD_ASL, 8'h00, 1'b1, 16'h101D));
    add_row(mk(cpu8x_pkg::CMD_ASL, 8'h80, 1'b0, 16'h101E));
    add_row(mk(cpu8x_pkg::CMD_LSR, 8'h00, 1'b1, 16'h101F));
    add_row(mk(cpu8x_pkg::CMD_LSR, 8'h01, 1'b0, 16'h1020));
    add_row(mk(cpu8x_pkg::CMD_ROL, 8'h00, 1'b1, 16'h1021));
    add_row(mk(cpu8x_pkg::CMD_ROL, 8'hFF, 1'b0, 16'h1022));
    add_row(mk(cpu8x_pkg::CMD_ROR, 8'h00, 1'b1, 16'h1023));
    add_row(mk(cpu8x_pkg::CMD_ROR, 8'h01, 1'b0, 16'h1024));
    // Memory increment and decrement with the accumulator select raised.
    add_row(mk(cpu8x_pkg::CMD_INC, 8'hFF, 1'b1, 16'h1025));
    add_row(mk(cpu8x_pkg::CMD_DEC, 8'h00, 1'b1, 16'h1026));
    add_row(mk(cpu8x_pkg::CMD_SEC, 8'h00, 1'b0, 16'h1027));
    add_row(mk(CMD_BCS, 8'h02, 1'b0, 16'h00FE));
    add_row(mk(cpu8x_pkg::CMD_CLC, 8'h00, 1'b0, 16'h1028));
    add_row(mk(CMD_BCC, 8'h80, 1'b0, 16'h1234));
    add_row(mk(CMD_BVS, 8'h10, 1'b0, 16'h2000));
    add_row(mk(cpu8x_pkg::CMD_CLV, 8'h00, 1'b0, 16'h1029));
    add_row(mk(CMD_BVC, 8'hF0, 1'b0, 16'h2005));
    add_row(mk(cpu8x_pkg::CMD_BPL, 8'h7F, 1'b0, 16'hFFF0));
    add_row(mk(CMD_BMI, 8'h7F, 1'b0, 16'hFFF0));
    add_row(mk(cpu8x_pkg::CMD_SED, 8'h00, 1'b0, 16'h102A));
    add_row(mk(cpu8x_pkg::CMD_ADC, 8'h09, 1'b0, 16'h102B));
    add_row(mk(cpu8x_pkg::CMD_CLD, 8'h00, 1'b0, 16'h102C));
    add_row(mk(cpu8x_pkg::CMD_CLI, 8'h00, 1'b0, 16'h102D));
    add_row(mk(cpu8x_pkg::CMD_SEI, 8'h00, 1'b0, 16'h102E));
    // Codes past the last branch behave as no operation.
    add_row(mk(CMD_UNUSED_LO, 8'hFF, 1'b1, 16'h102F));
    add_row(mk(CMD_UNUSED_HI, 8'hFF, 1'b1, 16'hFFFF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].w, dir_rows[k].fixed, dir_rows[k].want);
    end
    drain();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 2) begin
        drain();
      end
      send_word(rand_word(), 1'b0, '0);
    end
    drain();
    // Wait on to catch any stray word after the last one.
    repeat (8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cpu8x_pkg.sv
rtl/cpu8x_branch.sv
rtl/cpu8x_alu.sv
rtl/cpu8_register_alu_execute.sv
sim/tb_top.sv
